@@ hw/rtl/slc_pkg.sv @@
// Shared types and constants for the streaming linear convolution block.
`timescale 1ns / 1ps

package slc_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int RESULT_BITS  = 54;
  localparam int MAX_TAPS_DEF = 64;

  localparam logic OP_TAP    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] result;
    logic                          last_out;
  } out_item_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic shift;
    logic clr_hist;
    logic clr_taps;
    logic tap_we;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/streaming_linear_convolution.sv @@
// Top level of the streaming linear convolution: sequencer and chain of tap cells.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): op 0 loads the next kernel
// tap, op 1 pushes a signal sample. A transaction takes place on a rising edge with
// valid high and stall low. Taps are taken one per cycle when no sample is in work.
// A tap marked is_last completes the kernel; the next tap starts a fresh kernel.
// Output channel (out_valid_o / out_stall_i / out_data_o): one full-precision
// Q8.46 result per sample; a last sample also yields kernel-length-minus-one tail
// results, the final one flagged last_out.
// Each result is formed as the sample enters the delay line, every cell registers its
// product, and the partial sum ripples through the chain one cell per cycle into the
// output register. The input is stalled while a sample and its tail are in work, so no
// new tap or sample is taken until the last result of that sample enters the output
// register.
// A stalled result sits in the output register; the chain then holds its sum
// until the register frees. Reset clears the kernel and the delay line.
`timescale 1ns / 1ps

module streaming_linear_convolution #(
  parameter int MAX_TAPS = slc_pkg::MAX_TAPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  slc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output slc_pkg::out_item_t out_data_o
);

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SB    = slc_pkg::SAMPLE_BITS;
  localparam int RB    = slc_pkg::RESULT_BITS;

  slc_pkg::cell_ctrl_t  ctrl;
  logic [IDX_W-1:0]     tap_idx;
  logic signed [SB-1:0] hist_w [MAX_TAPS+1];
  logic signed [RB-1:0] acc_w  [MAX_TAPS+1];

  slc_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .acc_last_i   (acc_w[MAX_TAPS]),
    .ctrl_o       (ctrl),
    .tap_idx_o    (tap_idx),
    .shift_data_o (hist_w[0])
  );

  assign acc_w[0] = '0;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    slc_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .tap_idx_i  (tap_idx),
      .tap_data_i (in_data_i.sample),
      .hist_i     (hist_w[k]),
      .acc_i      (acc_w[k]),
      .hist_o     (hist_w[k+1]),
      .acc_o      (acc_w[k+1])
    );
  end

endmodule

@@ hw/rtl/slc_cell.sv @@
// One cell of the tap chain: kernel tap, delay-line slot, product and partial sum.
`timescale 1ns / 1ps

module slc_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  slc_pkg::cell_ctrl_t                    ctrl_i,
  input  logic [IDX_W-1:0]                       tap_idx_i,
  input  logic signed [slc_pkg::SAMPLE_BITS-1:0] tap_data_i,
  input  logic signed [slc_pkg::SAMPLE_BITS-1:0] hist_i,
  input  logic signed [slc_pkg::RESULT_BITS-1:0] acc_i,
  output logic signed [slc_pkg::SAMPLE_BITS-1:0] hist_o,
  output logic signed [slc_pkg::RESULT_BITS-1:0] acc_o
);

  localparam int SB = slc_pkg::SAMPLE_BITS;
  localparam int RB = slc_pkg::RESULT_BITS;

  logic signed [SB-1:0]   tap_q;
  logic signed [SB-1:0]   hist_q;
  logic signed [2*SB-1:0] prod_q;
  logic signed [RB-1:0]   acc_q;
  logic                   sel;

  assign sel = ctrl_i.tap_we && (tap_idx_i == IDX_W'(IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= '0;
      hist_q <= '0;
    end else begin
      if (ctrl_i.clr_taps) begin
        tap_q <= sel ? tap_data_i : '0;
      end else if (sel) begin
        tap_q <= tap_data_i;
      end
      if (ctrl_i.clr_hist) begin
        hist_q <= '0;
      end else if (ctrl_i.shift) begin
        hist_q <= hist_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= tap_q * hist_q;
    acc_q  <= acc_i + RB'(prod_q);
  end

  assign hist_o = hist_q;
  assign acc_o  = acc_q;

endmodule

@@ hw/rtl/slc_ctrl.sv @@
// Sequencer: kernel bookkeeping, sweep timing, tail generation and output register.
`timescale 1ns / 1ps

module slc_ctrl #(
  parameter int MAX_TAPS = slc_pkg::MAX_TAPS_DEF,
  parameter int IDX_W    = 6
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  slc_pkg::in_item_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output slc_pkg::out_item_t                     out_data_o,
  input  logic signed [slc_pkg::RESULT_BITS-1:0] acc_last_i,
  output slc_pkg::cell_ctrl_t                    ctrl_o,
  output logic [IDX_W-1:0]                       tap_idx_o,
  output logic signed [slc_pkg::SAMPLE_BITS-1:0] shift_data_o
);

  localparam int CW   = $clog2(MAX_TAPS + 1);
  localparam int TW   = $clog2(MAX_TAPS + 2);
  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0]         state_q, state_d;
  logic [CW-1:0]      load_q, load_d, klen_q, klen_d, rem_q, rem_d;
  logic               done_q, done_d, last_q, last_d;
  logic [TW-1:0]      cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  slc_pkg::out_item_t out_data_q;

  logic          in_acc, tap_acc, smp_acc, emit;
  logic [CW-1:0] load_eff, load_nxt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tap_acc    = in_acc && (in_data_i.op == slc_pkg::OP_TAP);
  assign smp_acc    = in_acc && (in_data_i.op == slc_pkg::OP_SAMPLE);
  assign emit       = (state_q == ST_RUN) && (cnt_q == TW'(MAX_TAPS + 1))
                      && (!out_valid_q || !out_stall_i);

  assign load_eff = done_q ? '0 : load_q;
  assign load_nxt = (load_eff < CW'(MAX_TAPS)) ? load_eff + CW'(1) : load_eff;

  assign ctrl_o.tap_we   = tap_acc && (load_eff < CW'(MAX_TAPS));
  assign ctrl_o.clr_taps = tap_acc && done_q;
  assign ctrl_o.clr_hist = (tap_acc && done_q) || (emit && last_q && (rem_q == '0));
  assign ctrl_o.shift    = smp_acc || (emit && (rem_q != '0));
  assign tap_idx_o       = load_eff[IDX_W-1:0];
  assign shift_data_o    = smp_acc ? in_data_i.sample : '0;

  always_comb begin
    state_d     = state_q;
    load_d      = load_q;
    klen_d      = klen_q;
    done_d      = done_q;
    rem_d       = rem_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (tap_acc) begin
      load_d = load_nxt;
      if (in_data_i.is_last) begin
        klen_d = load_nxt;
        done_d = 1'b1;
      end else if (done_q) begin
        klen_d = '0;
        done_d = 1'b0;
      end
    end
    if (smp_acc) begin
      state_d = ST_RUN;
      last_d  = in_data_i.is_last;
      rem_d   = (in_data_i.is_last && (klen_q != '0)) ? klen_q - CW'(1) : '0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (rem_q != '0) begin
        rem_d = rem_q - CW'(1);
      end else begin
        state_d = ST_IDLE;
      end
    end
    if (ctrl_o.shift) begin
      cnt_d = '0;
    end else if ((state_q == ST_RUN) && (cnt_q != TW'(MAX_TAPS + 1))) begin
      cnt_d = cnt_q + TW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_q      <= '0;
      klen_q      <= '0;
      done_q      <= 1'b0;
      rem_q       <= '0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_q      <= load_d;
      klen_q      <= klen_d;
      done_q      <= done_d;
      rem_q       <= rem_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.result   <= (klen_q == '0) ? '0 : acc_last_i;
      out_data_q.last_out <= last_q && (rem_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hw/rtl/slc_chk.sv @@
// Port-level checker for the streaming linear convolution, bound to the top level.
`timescale 1ns / 1ps

module slc_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input slc_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input slc_pkg::out_item_t out_data_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_smp_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.op == slc_pkg::OP_SAMPLE)
    |-> ##1 in_stall_o ##1 in_stall_o)
    else $error("sample transaction not followed by a busy sweep");

  a_tap_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.op == slc_pkg::OP_TAP) |=> !in_stall_o)
    else $error("tap transaction blocked the next input");

  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a sample in work");

endmodule

bind streaming_linear_convolution slc_chk u_slc_chk (.*);

@@ tb/streaming_linear_convolution_tb.sv @@
// Self-checking testbench for the streaming linear convolution block.
`timescale 1ns / 1ps

module streaming_linear_convolution_tb;

  localparam int MAX_TAPS  = slc_pkg::MAX_TAPS_DEF;
  localparam int SB        = slc_pkg::SAMPLE_BITS;
  localparam int RB        = slc_pkg::RESULT_BITS;
  localparam int LATENCY   = MAX_TAPS + 2;
  localparam int HOLD_CYC  = 1500;
  localparam int RND_ITEMS = 300;
  localparam int DIR_ROWS  = 18;

  typedef struct {
    logic                 op;
    logic signed [SB-1:0] smp;
    logic                 lst;
    bit                   typed;
    logic signed [RB-1:0] res;
    logic                 lo;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  slc_pkg::in_item_t  in_data = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  slc_pkg::out_item_t out_data_o;

  // predictor state
  logic signed [SB-1:0] coef [MAX_TAPS];
  logic signed [SB-1:0] dline [MAX_TAPS];
  int unsigned          coef_len;
  int unsigned          coef_loaded;
  bit                   coef_ready;

  slc_pkg::out_item_t conv_q [$];
  int unsigned        n_err;
  int unsigned        rnd_items;
  int unsigned        tx_idle_pct;
  int unsigned        rx_idle_pct;
  bit                 hold_req;
  bit                 hold_taken;
  int unsigned        hold_left;
  dir_row_t           dir_rows [DIR_ROWS];

  always #5 clk = ~clk;

  streaming_linear_convolution #(
    .MAX_TAPS(MAX_TAPS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  function automatic void expect_result(slc_pkg::out_item_t o);
    conv_q = {conv_q, o};
  endfunction

  function automatic logic signed [RB-1:0] fir_out();
    logic signed [63:0] acc;
    acc = '0;
    for (int k = 0; k < coef_len && k < MAX_TAPS; k++) begin
      acc += 64'(coef[k]) * 64'(dline[k]);
    end
    return acc[RB-1:0];
  endfunction

  function automatic void shift_in(logic signed [SB-1:0] x);
    for (int i = MAX_TAPS - 1; i > 0; i--) dline[i] = dline[i-1];
    dline[0] = x;
  endfunction

  function automatic void conv_predict(slc_pkg::in_item_t it, bit keep);
    slc_pkg::out_item_t o;
    if (it.op == slc_pkg::OP_TAP) begin
      if (coef_ready) begin
        foreach (coef[i]) coef[i] = '0;
        foreach (dline[i]) dline[i] = '0;
        coef_len    = 0;
        coef_loaded = 0;
        coef_ready  = 1'b0;
      end
      if (coef_loaded < MAX_TAPS) begin
        coef[coef_loaded] = it.sample;
        coef_loaded++;
      end
      if (it.is_last) begin
        coef_len   = coef_loaded;
        coef_ready = 1'b1;
      end
      return;
    end
    shift_in(it.sample);
    o.result   = fir_out();
    o.last_out = it.is_last && (coef_len <= 1);
    if (keep) expect_result(o);
    if (it.is_last) begin
      for (int t = 1; t < coef_len; t++) begin
        shift_in('0);
        o.result   = fir_out();
        o.last_out = (t + 1 == coef_len);
        if (keep) expect_result(o);
      end
      foreach (dline[i]) dline[i] = '0;
    end
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(19);
    unique case (r)
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic send_item(input slc_pkg::in_item_t it, input bit keep);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall_o);
    conv_predict(it, keep);
  endtask

  task automatic push_op(input logic op, input logic signed [SB-1:0] s, input logic lst);
    slc_pkg::in_item_t it;
    it.op      = op;
    it.sample  = s;
    it.is_last = lst;
    send_item(it, 1'b1);
    rnd_items++;
  endtask

  always @(posedge clk) begin : rx_side
    slc_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (conv_q.size() == 0) begin
          $error("unexpected transaction: result %0d last_out %0b",
                 out_data_o.result, out_data_o.last_out);
          n_err++;
        end else begin
          want = conv_q.pop_front();
          if (out_data_o.result !== want.result) begin
            $error("result: expected %0d, got %0d", want.result, out_data_o.result);
            n_err++;
          end
          if (out_data_o.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_data_o.last_out);
            n_err++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYC;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : stim
    slc_pkg::in_item_t  it;
    slc_pkg::out_item_t typed_res;
    int unsigned        r;
    int unsigned        len;
    int unsigned        n;
    bit                 first;
    n_err       = 0;
    rnd_items   = 0;
    tx_idle_pct = 9;
    rx_idle_pct = 69;
    hold_req    = 1'b0;
    hold_taken  = 1'b0;
    hold_left   = 0;
    first       = 1'b1;
    foreach (coef[i]) coef[i] = '0;
    foreach (dline[i]) dline[i] = '0;
    coef_len    = 0;
    coef_loaded = 0;
    coef_ready  = 1'b0;

    dir_rows = '{
      '{slc_pkg::OP_SAMPLE, 24'sh7FFFFF, 1'b0, 1'b1, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, 24'sh800000, 1'b1, 1'b1, 54'sd0, 1'b1},
      '{slc_pkg::OP_TAP,    24'sh7FFFFF, 1'b1, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, 24'sh7FFFFF, 1'b1, 1'b1, 54'sd70368727400449, 1'b1},
      '{slc_pkg::OP_TAP,    24'sh800000, 1'b1, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, 24'sh800000, 1'b1, 1'b1, 54'sd70368744177664, 1'b1},
      '{slc_pkg::OP_SAMPLE, 24'sh7FFFFF, 1'b1, 1'b1, -54'sd70368735789056, 1'b1},
      '{slc_pkg::OP_TAP,    24'sd100,    1'b0, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, 24'sd5,      1'b0, 1'b1, 54'sd0, 1'b0},
      '{slc_pkg::OP_TAP,    -24'sd3,     1'b0, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_TAP,    24'sd7,      1'b1, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, 24'sd1,      1'b0, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, -24'sd2,     1'b0, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, 24'sd3,      1'b1, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_TAP,    -24'sd1,     1'b0, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_TAP,    24'sh2AAAAA, 1'b1, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, 24'sh555555, 1'b0, 1'b0, 54'sd0, 1'b0},
      '{slc_pkg::OP_SAMPLE, 24'shD55555, 1'b1, 1'b0, 54'sd0, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.op      = dir_rows[i].op;
      it.sample  = dir_rows[i].smp;
      it.is_last = dir_rows[i].lst;
      send_item(it, !dir_rows[i].typed);
      if (dir_rows[i].typed) begin
        typed_res.result   = dir_rows[i].res;
        typed_res.last_out = dir_rows[i].lo;
        expect_result(typed_res);
      end
    end

    while (rnd_items < RND_ITEMS) begin
      if (rnd_items < RND_ITEMS / 3) begin
        tx_idle_pct = 9;
        rx_idle_pct = 69;
      end else if (rnd_items < 2 * RND_ITEMS / 3) begin
        tx_idle_pct = 69;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (rnd_items >= 50) hold_req = 1'b1;
      r = $urandom_range(99);
      if (first) begin
        // full-length kernel at the negative extreme, fed three samples at the same extreme
        first = 1'b0;
        for (int i = 0; i < MAX_TAPS; i++)
          push_op(slc_pkg::OP_TAP, 24'sh800000, i == MAX_TAPS - 1);
        for (int i = 0; i < 3; i++) push_op(slc_pkg::OP_SAMPLE, 24'sh800000, i == 2);
      end else if (r < 70) begin
        r = $urandom_range(99);
        if (r < 80) len = $urandom_range(1, 8);
        else if (r < 92) len = $urandom_range(9, MAX_TAPS);
        else len = $urandom_range(MAX_TAPS + 1, MAX_TAPS + 6);
        for (int i = 0; i < len; i++) push_op(slc_pkg::OP_TAP, pick_sample(), i == len - 1);
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) push_op(slc_pkg::OP_SAMPLE, pick_sample(), i == n - 1);
      end else if (r < 80) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) push_op(slc_pkg::OP_SAMPLE, pick_sample(), i == n - 1);
      end else if (r < 90) begin
        // kernel load left open, then samples meet an empty kernel
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) push_op(slc_pkg::OP_TAP, pick_sample(), 1'b0);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          push_op(slc_pkg::OP_SAMPLE, pick_sample(), (i == n - 1) && $urandom_range(1));
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          push_op(1'($urandom), pick_sample(), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (conv_q.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (n_err == 0) begin
      $display("streaming_linear_convolution_tb: PASS");
    end else begin
      $display("streaming_linear_convolution_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("streaming_linear_convolution_tb: FAIL");
    $finish;
  end

endmodule
